>>> hdl/dmst_pkg.sv
// ----------------------------------------------------------------------------
// dmst_pkg
// Shared types and constants of the display mode set table: mode record,
// request codes and the fixed table of default modes.
// ----------------------------------------------------------------------------
package dmst_pkg;

  localparam int unsigned DEFAULT_COUNT = 15;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;
  localparam logic [1:0] ACT_FIND   = 2'd3;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [9:0]  hz;
  } mode_t;

  localparam mode_t DEFAULT_MODES [DEFAULT_COUNT] = '{
    '{16'd1920, 16'd1080, 10'd60},  '{16'd1920, 16'd1080, 10'd120},
    '{16'd1920, 16'd1080, 10'd144}, '{16'd1920, 16'd1080, 10'd240},
    '{16'd1280, 16'd720,  10'd60},  '{16'd1600, 16'd900,  10'd60},
    '{16'd1920, 16'd1200, 10'd60},  '{16'd2560, 16'd1440, 10'd60},
    '{16'd2560, 16'd1440, 10'd120}, '{16'd2560, 16'd1440, 10'd144},
    '{16'd2560, 16'd1600, 10'd60},  '{16'd3440, 16'd1440, 10'd60},
    '{16'd3440, 16'd1440, 10'd100}, '{16'd3840, 16'd2160, 10'd60},
    '{16'd3840, 16'd2160, 10'd120}
  };

endpackage

>>> hdl/dmst_ram.sv
// ----------------------------------------------------------------------------
// dmst_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module dmst_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/display_mode_set_table.sv
// ----------------------------------------------------------------------------
// display_mode_set_table
// Set of display modes: fixed default table plus an ordered custom store held
// in one RAM. A sequencer scans, appends, compacts and lists the store.
// ----------------------------------------------------------------------------
// Find, rejected add and default-hit add: result in the cycle after the request.
// Add/remove scan the store entry by entry, each read through the registered
// RAM port; remove then moves every later entry down one slot. List gives the
// default entries from the table, custom entries via RAM reads. One request at
// a time; the next is taken in the first cycle busy_o is low; results cannot be stalled.
// Reset clears the custom count and sequencer state; store contents are never cleared.
module display_mode_set_table #(
  parameter int unsigned CUSTOM_CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] req_width_i,
  input  logic [15:0] req_height_i,
  input  logic [9:0]  req_hz_i,
  input  logic [4:0]  list_limit_i,
  output logic        result_valid_o,
  output logic        ok_o,
  output logic        entry_valid_o,
  output logic [15:0] mode_width_o,
  output logic [15:0] mode_height_o,
  output logic [9:0]  mode_hz_o,
  output logic [3:0]  mode_index_o,
  output logic [4:0]  total_modes_o,
  output logic        last_o
);

  import dmst_pkg::*;

  localparam int unsigned AW   = (CUSTOM_CAPACITY > 1) ? $clog2(CUSTOM_CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CUSTOM_CAPACITY + 1);
  localparam int unsigned SUMW = ((CW > 4) ? CW : 4) + 1;
  localparam int unsigned MW   = $bits(mode_t);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN_RD   = 3'd1;
  localparam logic [2:0] S_SCAN_CMP  = 3'd2;
  localparam logic [2:0] S_SHIFT_RD  = 3'd3;
  localparam logic [2:0] S_SHIFT_WR  = 3'd4;
  localparam logic [2:0] S_LIST      = 3'd5;
  localparam logic [2:0] S_LIST_WAIT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [4:0]    list_q, list_d;
  logic [4:0]    n_q, n_d;
  logic [1:0]    act_q;
  mode_t         req_q;

  mode_t         req_in;
  logic          req_zero;
  logic          dflt_hit;
  logic [3:0]    dflt_idx;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;
  mode_t         rd_mode;

  logic [CW-1:0] ptr_m1;
  logic [4:0]    cust_off;
  logic          list_last;
  logic [SUMW-1:0] sum_cur, sum_nxt;
  logic [4:0]    total_cur, total_nxt;
  logic [4:0]    list_n;

  logic          emit;
  logic          r_ok, r_ev, r_last;
  mode_t         r_mode;
  logic [3:0]    r_idx;

  logic          valid_q, ok_q, ev_q, last_q;
  mode_t         mode_q;
  logic [3:0]    idx_q;
  logic [4:0]    tot_q;

  assign req_in   = '{width: req_width_i, height: req_height_i, hz: req_hz_i};
  assign req_zero = (req_width_i == '0) || (req_height_i == '0) || (req_hz_i == '0);
  assign rd_mode  = mode_t'(ram_rdata);

  // First match wins: walk down so the lowest index is kept.
  always_comb begin
    dflt_hit = 1'b0;
    dflt_idx = '0;
    for (int k = DEFAULT_COUNT - 1; k >= 0; k--) begin
      if (DEFAULT_MODES[k] == req_in) begin
        dflt_hit = 1'b1;
        dflt_idx = 4'(k);
      end
    end
  end

  assign sum_cur   = SUMW'(DEFAULT_COUNT) + SUMW'(count_q);
  assign sum_nxt   = SUMW'(DEFAULT_COUNT) + SUMW'(count_d);
  assign total_cur = (sum_cur > SUMW'(31)) ? 5'd31 : sum_cur[4:0];
  assign total_nxt = (sum_nxt > SUMW'(31)) ? 5'd31 : sum_nxt[4:0];
  assign list_n    = (list_limit_i < total_cur) ? list_limit_i : total_cur;

  assign ptr_m1    = ptr_q - CW'(1);
  assign cust_off  = list_q - 5'(DEFAULT_COUNT);
  assign list_last = ((list_q + 5'd1) == n_q);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    list_d    = list_q;
    n_d       = n_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = MW'(req_q);
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];
    emit      = 1'b0;
    r_ok      = 1'b0;
    r_ev      = 1'b0;
    r_mode    = '0;
    r_idx     = '0;
    r_last    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            ACT_ADD: begin
              if (req_zero) begin
                emit = 1'b1;
              end else if (dflt_hit) begin
                emit = 1'b1;
                r_ok = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            ACT_REMOVE: begin
              ptr_d   = '0;
              state_d = S_SCAN_RD;
            end
            ACT_LIST: begin
              if (list_n == '0) begin
                emit = 1'b1;
                r_ok = 1'b1;
              end else begin
                list_d  = '0;
                n_d     = list_n;
                state_d = S_LIST;
              end
            end
            ACT_FIND: begin
              emit  = 1'b1;
              r_ok  = dflt_hit;
              r_idx = dflt_hit ? dflt_idx : 4'd0;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (ptr_q == count_q) begin
          // No match in the store: append on add if there is room.
          emit    = 1'b1;
          state_d = S_IDLE;
          if ((act_q == ACT_ADD) && (count_q < CW'(CUSTOM_CAPACITY))) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            count_d   = count_q + CW'(1);
            r_ok      = 1'b1;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        ptr_d = ptr_q + CW'(1);
        if (rd_mode == req_q) begin
          if (act_q == ACT_ADD) begin
            emit    = 1'b1;
            r_ok    = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (ptr_q == count_q) begin
          count_d = count_q - CW'(1);
          emit    = 1'b1;
          r_ok    = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // Move entry down one slot.
        ram_we    = 1'b1;
        ram_waddr = ptr_m1[AW-1:0];
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + CW'(1);
        state_d   = S_SHIFT_RD;
      end
      S_LIST: begin
        if (list_q < 5'(DEFAULT_COUNT)) begin
          emit    = 1'b1;
          r_ok    = 1'b1;
          r_ev    = 1'b1;
          r_mode  = DEFAULT_MODES[list_q[3:0]];
          r_last  = list_last;
          list_d  = list_q + 5'd1;
          state_d = list_last ? S_IDLE : S_LIST;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cust_off);
          state_d   = S_LIST_WAIT;
        end
      end
      S_LIST_WAIT: begin
        emit    = 1'b1;
        r_ok    = 1'b1;
        r_ev    = 1'b1;
        r_mode  = rd_mode;
        r_last  = list_last;
        list_d  = list_q + 5'd1;
        state_d = list_last ? S_IDLE : S_LIST;
      end
      default: state_d = S_IDLE;
    endcase
  end

  dmst_ram #(
    .WIDTH (MW),
    .DEPTH (CUSTOM_CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      list_q  <= '0;
      n_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      list_q  <= list_d;
      n_q     <= n_d;
      valid_q <= emit;
    end
  end

  // Hold the request for the duration of the transaction.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      act_q <= action_i;
      req_q <= req_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ok_q   <= r_ok;
      ev_q   <= r_ev;
      mode_q <= r_mode;
      idx_q  <= r_idx;
      tot_q  <= total_nxt;
      last_q <= r_last;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign ok_o           = ok_q;
  assign entry_valid_o  = ev_q;
  assign mode_width_o   = mode_q.width;
  assign mode_height_o  = mode_q.height;
  assign mode_hz_o      = mode_q.hz;
  assign mode_index_o   = idx_q;
  assign total_modes_o  = tot_q;
  assign last_o         = last_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CUSTOM_CAPACITY))
    else $error("custom count above capacity");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("non-final result while sequencer idle");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("store write outside a transaction");

  a_count_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> result_valid_o)
    else $error("count changed without a result");

endmodule

>>> verif/dmst_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// dmst_scoreboard_pkg
// Result record and scoreboard of the display mode set table bench. The
// scoreboard keeps its own copy of the custom store, turns each accepted
// request into the results it must produce and checks strobed results in order.
// ----------------------------------------------------------------------------
package dmst_scoreboard_pkg;

  import dmst_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        entry_valid;
    logic [15:0] width;
    logic [15:0] height;
    logic [9:0]  hz;
    logic [3:0]  index;
    logic [4:0]  total;
    logic        last;
  } mode_result_t;

  localparam int unsigned REPORT_CAP = 100;

  class mode_table_scoreboard;

    int unsigned  capacity;
    mode_t        custom_store[$];
    mode_result_t due_results[$];
    int unsigned  errors;
    int unsigned  checked;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
      checked  = 0;
    endfunction

    function int default_index(mode_t m);
      for (int i = 0; i < DEFAULT_COUNT; i++) begin
        if (DEFAULT_MODES[i] == m) return i;
      end
      return -1;
    endfunction

    function int stored_index(mode_t m);
      for (int i = 0; i < custom_store.size(); i++) begin
        if (custom_store[i] == m) return i;
      end
      return -1;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t: %s", $time, msg);
      end else if (errors == REPORT_CAP + 1) begin
        $display("%0t: further mismatches suppressed", $time);
      end
    endfunction

    // Total is taken after the request has changed the store.
    function void push_result(logic ok, logic ev, mode_t m, logic [3:0] idx, logic last);
      mode_result_t r;
      int unsigned  t;
      t = DEFAULT_COUNT + custom_store.size();
      if (t > 31) t = 31;
      r.ok          = ok;
      r.entry_valid = ev;
      r.width       = m.width;
      r.height      = m.height;
      r.hz          = m.hz;
      r.index       = idx;
      r.total       = t[4:0];
      r.last        = last;
      due_results.push_back(r);
    endfunction

    function void note_request(logic [1:0] act, mode_t m, logic [4:0] lim);
      int          d;
      int          s;
      int unsigned n;
      int unsigned total;
      logic        ok;
      mode_t       blank;
      blank = '0;
      case (act)
        ACT_ADD: begin
          ok = 1'b0;
          if (m.width != 0 && m.height != 0 && m.hz != 0) begin
            if (default_index(m) >= 0 || stored_index(m) >= 0) begin
              ok = 1'b1;
            end else if (custom_store.size() < capacity) begin
              custom_store.push_back(m);
              ok = 1'b1;
            end
          end
          push_result(ok, 1'b0, blank, 4'd0, 1'b1);
        end
        ACT_REMOVE: begin
          s = stored_index(m);
          if (s >= 0) custom_store.delete(s);
          push_result(s >= 0, 1'b0, blank, 4'd0, 1'b1);
        end
        ACT_LIST: begin
          total = DEFAULT_COUNT + custom_store.size();
          n     = (lim < total) ? lim : total;
          if (n == 0) begin
            push_result(1'b1, 1'b0, blank, 4'd0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              push_result(1'b1, 1'b1,
                          (i < DEFAULT_COUNT) ? DEFAULT_MODES[i]
                                              : custom_store[i - DEFAULT_COUNT],
                          4'd0, i + 1 == n);
            end
          end
        end
        default: begin
          d = default_index(m);
          if (d >= 0) push_result(1'b1, 1'b0, blank, d[3:0], 1'b1);
          else        push_result(1'b0, 1'b0, blank, 4'd0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        report($sformatf("%s mismatch: expected %0d, actual %0d", name, want, got));
      end
    endfunction

    function void check_result(mode_result_t got);
      mode_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result: expected none, actual %h", got));
        return;
      end
      want = due_results.pop_front();
      compare_field("ok",          want.ok,          got.ok);
      compare_field("entry_valid", want.entry_valid, got.entry_valid);
      compare_field("mode_width",  want.width,       got.width);
      compare_field("mode_height", want.height,      got.height);
      compare_field("mode_hz",     want.hz,          got.hz);
      compare_field("mode_index",  want.index,       got.index);
      compare_field("total_modes", want.total,       got.total);
      compare_field("last",        want.last,        got.last);
    endfunction

  endclass

endpackage

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench of the display mode set table. A directed pass covers the default
// table edges, rejected and duplicate adds, removes with shift and empty and
// partial lists; a random pass then grows and shrinks the custom store.
// ----------------------------------------------------------------------------
module tb;

  import dmst_pkg::*;
  import dmst_scoreboard_pkg::*;

  localparam int unsigned CUSTOM_CAPACITY = 16;
  localparam int unsigned RANDOM_ITEMS    = 88;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES     = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  action_i;
  logic [15:0] req_width_i;
  logic [15:0] req_height_i;
  logic [9:0]  req_hz_i;
  logic [4:0]  list_limit_i;
  logic        result_valid_o;
  logic        ok_o;
  logic        entry_valid_o;
  logic [15:0] mode_width_o;
  logic [15:0] mode_height_o;
  logic [9:0]  mode_hz_o;
  logic [3:0]  mode_index_o;
  logic [4:0]  total_modes_o;
  logic        last_o;

  mode_table_scoreboard sb;
  int unsigned          req_count [4];
  int unsigned          peak_store;
  int unsigned          quiet_cycles;
  int unsigned          burst_left;

  display_mode_set_table #(
    .CUSTOM_CAPACITY(CUSTOM_CAPACITY)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .req_width_i   (req_width_i),
    .req_height_i  (req_height_i),
    .req_hz_i      (req_hz_i),
    .list_limit_i  (list_limit_i),
    .result_valid_o(result_valid_o),
    .ok_o          (ok_o),
    .entry_valid_o (entry_valid_o),
    .mode_width_o  (mode_width_o),
    .mode_height_o (mode_height_o),
    .mode_hz_o     (mode_hz_o),
    .mode_index_o  (mode_index_o),
    .total_modes_o (total_modes_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_result({ok_o, entry_valid_o, mode_width_o, mode_height_o, mode_hz_o,
                       mode_index_o, total_modes_o, last_o});
    end
  end

  // Count cycles with neither a request nor a result transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               sb.due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] act, input mode_t m, input logic [4:0] lim);
    @(negedge clk_i);
    start_i      = 1'b1;
    action_i     = act;
    req_width_i  = m.width;
    req_height_i = m.height;
    req_hz_i     = m.hz;
    list_limit_i = lim;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    sb.note_request(act, m, lim);
    req_count[act]++;
    if (sb.custom_store.size() > peak_store) peak_store = sb.custom_store.size();
  endtask

  // Drop start for a random number of cycles; hold it through bursts.
  task automatic pause_between();
    int r;
    int n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    r = $urandom_range(0, 19);
    if (r == 0) begin
      burst_left = $urandom_range(10, 25);
      n = 0;
    end else if (r < 10) begin
      n = 0;
    end else if (r < 18) begin
      n = $urandom_range(1, 4);
    end else begin
      n = $urandom_range(15, 60);
    end
    if (n > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic mode_t pick_mode(input bit prefer_stored);
    int    r;
    mode_t m;
    r = $urandom_range(0, 9);
    if (prefer_stored && $urandom_range(0, 3) != 0) r = 2;
    m.width  = 16'($urandom);
    m.height = 16'($urandom);
    m.hz     = 10'($urandom_range(0, 1023));
    case (r)
      0, 1: m = DEFAULT_MODES[$urandom_range(0, DEFAULT_COUNT - 1)];
      2, 3, 4: begin
        if (sb.custom_store.size() > 0) begin
          m = sb.custom_store[$urandom_range(0, sb.custom_store.size() - 1)];
        end
      end
      5: begin
        case ($urandom_range(0, 2))
          0:       m.width  = '0;
          1:       m.height = '0;
          default: m.hz     = '0;
        endcase
      end
      default: ;
    endcase
    return m;
  endfunction

  initial begin
    int    r;
    mode_t big;
    mode_t tiny;
    sb           = new(CUSTOM_CAPACITY);
    peak_store   = 0;
    burst_left   = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    action_i     = ACT_ADD;
    req_width_i  = '0;
    req_height_i = '0;
    req_hz_i     = '0;
    list_limit_i = '0;
    foreach (req_count[i]) req_count[i] = 0;
    big  = '{16'hFFFF, 16'hFFFF, 10'h3FF};
    tiny = '{16'd1, 16'd1, 10'd1};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: default table edges, absent modes, empty and short lists.
    send_request(ACT_FIND,   DEFAULT_MODES[0], 5'd0);
    send_request(ACT_FIND,   DEFAULT_MODES[DEFAULT_COUNT - 1], 5'd31);
    send_request(ACT_FIND,   '{16'd1920, 16'd1080, 10'd61}, 5'd0);
    send_request(ACT_FIND,   '0, 5'd0);
    send_request(ACT_LIST,   '0, 5'd0);
    send_request(ACT_LIST,   '0, 5'd31);
    send_request(ACT_LIST,   '0, 5'd1);
    // Adds with a zero field, a default hit, new modes and a duplicate.
    send_request(ACT_ADD,    '{16'd0, 16'd1080, 10'd60}, 5'd0);
    send_request(ACT_ADD,    '{16'd1920, 16'd0, 10'd60}, 5'd0);
    send_request(ACT_ADD,    '{16'd1920, 16'd1080, 10'd0}, 5'd0);
    send_request(ACT_ADD,    DEFAULT_MODES[7], 5'd0);
    send_request(ACT_ADD,    big, 5'd0);
    send_request(ACT_ADD,    big, 5'd0);
    send_request(ACT_ADD,    tiny, 5'd0);
    send_request(ACT_ADD,    '{16'd800, 16'd600, 10'd75}, 5'd0);
    // Removes: default mode, all-zero mode, first custom entry with shift.
    send_request(ACT_REMOVE, DEFAULT_MODES[0], 5'd0);
    send_request(ACT_REMOVE, '0, 5'd0);
    send_request(ACT_REMOVE, big, 5'd0);
    send_request(ACT_REMOVE, big, 5'd0);
    send_request(ACT_LIST,   '0, 5'd16);
    send_request(ACT_LIST,   '0, 5'd31);
    send_request(ACT_FIND,   tiny, 5'd0);

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      pause_between();
      r = $urandom_range(0, 19);
      if (r < 10)      send_request(ACT_ADD,    pick_mode(1'b0), 5'($urandom_range(0, 31)));
      else if (r < 14) send_request(ACT_REMOVE, pick_mode(1'b1), 5'($urandom_range(0, 31)));
      else if (r < 17) send_request(ACT_LIST,   pick_mode(1'b0), 5'($urandom_range(0, 31)));
      else             send_request(ACT_FIND,   pick_mode(1'b0), 5'($urandom_range(0, 31)));
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Requests: %0d add, %0d remove, %0d list, %0d find; %0d results checked",
             req_count[ACT_ADD], req_count[ACT_REMOVE], req_count[ACT_LIST],
             req_count[ACT_FIND], sb.checked);
    $display("Custom store peaked at %0d of %0d entries", peak_store, CUSTOM_CAPACITY);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
